@@ design/mep_pkg.sv @@
package mep_pkg;

  localparam int DEC_W = 48;
  localparam int SCR_W = 11;
  localparam int CEN_W = 11;
  localparam int CRD_W = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [SCR_W-1:0] MID_X_RESET = 11'd320;
  localparam logic [SCR_W-1:0] MID_Y_RESET = 11'd240;

  localparam logic [CFG_IDX_W-1:0] REG_MID_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_Y = 1'b1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQA,
    S_SQB,
    S_AY0,
    S_INIT,
    S_MBX,
    S_MAY,
    S_DECIDE,
    S_XX,
    S_BXX,
    S_YY,
    S_AYY,
    S_SW1,
    S_SW2,
    S_AB,
    S_SW3,
    S_R2,
    S_EMIT,
    S_NULL
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_A,
    OP_SQ_B,
    OP_MUL_AY,
    OP_INIT,
    OP_MUL_BX,
    OP_R1,
    OP_R2,
    OP_MUL_XX,
    OP_MUL_BXX,
    OP_MUL_YY,
    OP_MUL_AYY,
    OP_SW1,
    OP_SW2,
    OP_MUL_AB,
    OP_SW3,
    OP_EMIT,
    OP_NULL
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lt;        // ry^2*x < rx^2*y
    logic region;    // region two
    logic active;
    logic out_busy;  // result held and not taken this cycle
  } dp_status_t;

endpackage

@@ design/mep_ctrl.sv @@
module mep_ctrl
  import mep_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_START) begin
            cmd.op    = OP_LOAD;
            state_nxt = S_SQA;
          end else if (status.active) begin
            state_nxt = S_MBX;
          end else begin
            state_nxt = S_NULL;
          end
        end
      end
      S_SQA: begin
        cmd.op    = OP_SQ_A;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.op    = OP_SQ_B;
        state_nxt = S_AY0;
      end
      S_AY0: begin
        cmd.op    = OP_MUL_AY;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_EMIT;
      end
      S_MBX: begin
        cmd.op    = OP_MUL_BX;
        state_nxt = S_MAY;
      end
      S_MAY: begin
        cmd.op    = OP_MUL_AY;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.region) begin
          cmd.op    = OP_R2;
          state_nxt = S_EMIT;
        end else if (status.lt) begin
          cmd.op    = OP_R1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_XX;
        end
      end
      // region two set-up
      S_XX: begin
        cmd.op    = OP_MUL_XX;
        state_nxt = S_BXX;
      end
      S_BXX: begin
        cmd.op    = OP_MUL_BXX;
        state_nxt = S_YY;
      end
      S_YY: begin
        cmd.op    = OP_MUL_YY;
        state_nxt = S_AYY;
      end
      S_AYY: begin
        cmd.op    = OP_MUL_AYY;
        state_nxt = S_SW1;
      end
      S_SW1: begin
        cmd.op    = OP_SW1;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.op    = OP_SW2;
        state_nxt = S_AB;
      end
      S_AB: begin
        cmd.op    = OP_MUL_AB;
        state_nxt = S_SW3;
      end
      S_SW3: begin
        cmd.op    = OP_SW3;
        state_nxt = S_R2;
      end
      S_R2: begin
        cmd.op    = OP_R2;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_NULL: begin
        if (!status.out_busy) begin
          cmd.op    = OP_NULL;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT || cmd.op == OP_NULL) |-> !status.out_busy)
    else $error("result written over an untaken one");

  a_r1_region: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_R1) |-> (!status.region && status.lt))
    else $error("region one step outside region one");

  a_step_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MBX) |-> $past(in_valid && in_ready && in_func == FUNC_STEP))
    else $error("step started without a transfer");
`endif

endmodule

@@ design/mep_dp.sv @@
module mep_dp
  import mep_pkg::*;
#(
  parameter int RADIUS_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SCR_W-1:0]        cfg_data,
  input  logic signed [CEN_W-1:0] in_center_x,
  input  logic signed [CEN_W-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]  in_radius_x,
  input  logic [RADIUS_BITS-1:0]  in_radius_y,
  input  ctrl_cmd_t               cmd,
  output dp_status_t              status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_valid_res,
  output logic signed [CRD_W-1:0] out_px_right,
  output logic signed [CRD_W-1:0] out_px_left,
  output logic signed [CRD_W-1:0] out_py_lower,
  output logic signed [CRD_W-1:0] out_py_upper,
  output logic                    out_last
);

  localparam int RB = RADIUS_BITS;
  localparam int SQ_W = 2 * RB;
  localparam int PR_W = 4 * RB;

  logic [SCR_W-1:0] mid_x_r, mid_y_r;
  logic [RB-1:0]    x_r, y_r, rad_r;
  logic [SQ_W-1:0]  a_r, b_r;
  logic [DEC_W-1:0] dec_r, bx_r, ay_r, t1_r, t2_r;
  logic [CEN_W-1:0] cx_r, cy_r;
  logic             region_r, active_r;

  logic             out_valid_r, out_valid_res_r, out_last_r;
  logic [CRD_W-1:0] px_right_r, px_left_r, py_lower_r, py_upper_r;

  logic [SQ_W-1:0]        mul_a, mul_b;
  logic [PR_W-1:0]        prod;
  logic [PR_W+DEC_W-1:0]  prod_ext;
  logic [DEC_W-1:0]       prod48;
  logic [SQ_W-1:0]        x_ext, y_ext, rad_ext;
  logic [DEC_W-1:0]       ae, be, bx_next, ay_prev;
  logic                   dec_pos;
  logic [RB+CRD_W-1:0]    x_wide, y_wide;
  logic [CRD_W-1:0]       x13, y13, sx, sy;

  assign x_ext   = {{RB{1'b0}}, x_r};
  assign y_ext   = {{RB{1'b0}}, y_r};
  assign rad_ext = {{RB{1'b0}}, rad_r};

  // one shared multiplier, result always registered
  always_comb begin
    mul_a = a_r;
    mul_b = y_ext;
    case (cmd.op)
      OP_SQ_A: begin
        mul_a = rad_ext;
        mul_b = rad_ext;
      end
      OP_SQ_B, OP_MUL_YY: begin
        mul_a = y_ext;
        mul_b = y_ext;
      end
      OP_MUL_AY: begin
        mul_a = a_r;
        mul_b = y_ext;
      end
      OP_MUL_BX: begin
        mul_a = b_r;
        mul_b = x_ext;
      end
      OP_MUL_XX: begin
        mul_a = x_ext;
        mul_b = x_ext;
      end
      OP_MUL_BXX: begin
        mul_a = b_r;
        mul_b = t1_r[SQ_W-1:0];
      end
      OP_MUL_AYY: begin
        mul_a = a_r;
        mul_b = t2_r[SQ_W-1:0];
      end
      OP_MUL_AB: begin
        mul_a = a_r;
        mul_b = b_r;
      end
      default: begin
        mul_a = a_r;
        mul_b = y_ext;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {{DEC_W{1'b0}}, prod};
  assign prod48   = prod_ext[DEC_W-1:0];

  assign ae      = {{(DEC_W-SQ_W){1'b0}}, a_r};
  assign be      = {{(DEC_W-SQ_W){1'b0}}, b_r};
  assign bx_next = bx_r + be;   // b*(x+1)
  assign ay_prev = ay_r - ae;   // a*(y-1)
  assign dec_pos = !dec_r[DEC_W-1] && (dec_r != '0);

  assign x_wide = {{CRD_W{1'b0}}, x_r};
  assign y_wide = {{CRD_W{1'b0}}, y_r};
  assign x13    = x_wide[CRD_W-1:0];
  assign y13    = y_wide[CRD_W-1:0];
  assign sx     = {2'b00, mid_x_r} + {{(CRD_W-CEN_W){cx_r[CEN_W-1]}}, cx_r};
  assign sy     = {2'b00, mid_y_r} - {{(CRD_W-CEN_W){cy_r[CEN_W-1]}}, cy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_x_r <= MID_X_RESET;
      mid_y_r <= MID_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MID_X: mid_x_r <= cfg_data;
        REG_MID_Y: mid_y_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        active_r <= (y_r != '0);
      end
      if (cmd.op == OP_EMIT || cmd.op == OP_NULL) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cx_r     <= in_center_x;
        cy_r     <= in_center_y;
        rad_r    <= in_radius_x;
        x_r      <= '0;
        y_r      <= in_radius_y;
        region_r <= 1'b0;
      end
      OP_SQ_A:    a_r  <= prod[SQ_W-1:0];
      OP_SQ_B:    b_r  <= prod[SQ_W-1:0];
      OP_MUL_AY:  ay_r <= prod48;
      OP_MUL_BX:  bx_r <= prod48;
      OP_MUL_XX,
      OP_MUL_BXX,
      OP_MUL_AB:  t1_r <= prod48;
      OP_MUL_YY,
      OP_MUL_AYY: t2_r <= prod48;
      OP_INIT: begin
        dec_r <= (be << 2) - (ay_r << 2) + ae;
      end
      OP_SW1: begin
        dec_r <= (t1_r << 2) + (bx_r << 2) + be;
      end
      OP_SW2: begin
        dec_r <= dec_r + (t2_r << 2) - (ay_r << 3) + (ae << 2);
      end
      OP_SW3: begin
        dec_r    <= dec_r - (t1_r << 2);
        region_r <= 1'b1;
      end
      OP_R1: begin
        x_r <= x_r + RB'(1);
        if (dec_r[DEC_W-1]) begin
          dec_r <= dec_r + (bx_next << 3) + (be << 2);
        end else begin
          y_r   <= y_r - RB'(1);
          dec_r <= dec_r + (bx_next << 3) - (ay_prev << 3) + (be << 2);
        end
      end
      OP_R2: begin
        y_r <= y_r - RB'(1);
        if (dec_pos) begin
          dec_r <= dec_r + (ae << 2) - (ay_prev << 3);
        end else begin
          x_r   <= x_r + RB'(1);
          dec_r <= dec_r + (bx_next << 3) - (ay_prev << 3) + (ae << 2);
        end
      end
      OP_EMIT: begin
        out_valid_res_r <= 1'b1;
        px_right_r      <= sx + x13;
        px_left_r       <= sx - x13;
        py_lower_r      <= sy + y13;
        py_upper_r      <= sy - y13;
        out_last_r      <= (y_r == '0);
      end
      OP_NULL: begin
        out_valid_res_r <= 1'b0;
        px_right_r      <= '0;
        px_left_r       <= '0;
        py_lower_r      <= '0;
        py_upper_r      <= '0;
        out_last_r      <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign status.lt       = (bx_r < ay_r);
  assign status.region   = region_r;
  assign status.active   = active_r;
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_valid_res_r;
  assign out_px_right  = px_right_r;
  assign out_px_left   = px_left_r;
  assign out_py_lower  = py_lower_r;
  assign out_py_upper  = py_upper_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT && y_r == '0) |=> !active_r)
    else $error("ellipse still active after its last point");

  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(region_r) |-> $past(cmd.op == OP_LOAD))
    else $error("region two left without a start");

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_NULL) |=> (!out_valid_res && !out_last && out_px_right == '0))
    else $error("idle step result not cleared");
`endif

endmodule

@@ design/midpoint_ellipse_point_generator_core.sv @@
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    func, centre x/y, radius x/y
// out      output     out_valid / out_ready  valid_res, four screen coords, last
// cfg      input      cfg_we                 cfg_index, cfg_data (screen centre)
//
// one item at a time through a single shared multiplier
// start squares radii; step forms b*x, a*y; region two entry adds a set-up
// a result waits in the output register while the next item is taken
// the result write holds while out_valid is high and out_ready low
// synchronous active-low reset, screen centre returns to 320 / 240
module midpoint_ellipse_point_generator_core
  import mep_pkg::*;
#(
  parameter int RADIUS_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SCR_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic signed [CEN_W-1:0] in_center_x,
  input  logic signed [CEN_W-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]  in_radius_x,
  input  logic [RADIUS_BITS-1:0]  in_radius_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_valid_res,
  output logic signed [CRD_W-1:0] out_px_right,
  output logic signed [CRD_W-1:0] out_px_left,
  output logic signed [CRD_W-1:0] out_py_lower,
  output logic signed [CRD_W-1:0] out_py_upper,
  output logic                    out_last
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .status   (status),
    .cmd      (cmd)
  );

  mep_dp #(
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_radius_x   (in_radius_x),
    .in_radius_y   (in_radius_y),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_valid_res (out_valid_res),
    .out_px_right  (out_px_right),
    .out_px_left   (out_px_left),
    .out_py_lower  (out_py_lower),
    .out_py_upper  (out_py_upper),
    .out_last      (out_last)
  );

endmodule
